// ----- rtl/mexp_pkg.sv -----
// Shared types and constants of the modular exponentiation block.
// Depends on nothing; every module of the block imports it.
package mexp_pkg;

    localparam int OP_BITS  = 31;
    localparam int CNT_BITS = $clog2(OP_BITS);
    localparam int SUM_BITS = OP_BITS + 1;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(OP_BITS - 1);

    typedef logic [OP_BITS-1:0]  operand_t;
    typedef logic [CNT_BITS-1:0] cnt_t;
    typedef logic [SUM_BITS-1:0] sum_t;

    // Register indexes of the configuration port
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    typedef struct packed {
        operand_t exponent;
        operand_t modulus;
    } cfg_t;

endpackage

// ----- rtl/mexp_addmod.sv -----
// Shared modular add unit: (a + b + cin) mod m for a, b < m.
// Depends on mexp_pkg.
module mexp_addmod (
    input  mexp_pkg::operand_t a_in,
    input  mexp_pkg::operand_t b_in,
    input  logic               cin,
    input  mexp_pkg::operand_t mod_in,
    output mexp_pkg::operand_t y_out
);
    import mexp_pkg::*;

    sum_t sum;
    sum_t diff;

    assign sum  = SUM_BITS'(a_in) + SUM_BITS'(b_in) + SUM_BITS'(cin);
    assign diff = sum - SUM_BITS'(mod_in);

    // The sum stays below twice the modulus, so one subtract suffices
    assign y_out = (sum >= SUM_BITS'(mod_in)) ? diff[OP_BITS-1:0] : sum[OP_BITS-1:0];

endmodule

// ----- rtl/mexp_core.sv -----
// Sequencer of the square-and-multiply exponentiation around the shared add unit.
// Depends on mexp_pkg and mexp_addmod.
module mexp_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  mexp_pkg::cfg_t     cfg,
    input  logic               start,
    input  mexp_pkg::operand_t base_value,
    output logic               busy,
    output logic               done_valid,
    input  logic               done_take,
    output mexp_pkg::operand_t result
);
    import mexp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_NEXT   = 6'b000100,
        ST_DBL    = 6'b001000,
        ST_ADD    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t   state_reg, state_next;
    operand_t base_reg, base_next;
    operand_t acc_reg, acc_next;
    operand_t sq_reg, sq_next;
    operand_t r_reg, r_next;
    operand_t e_reg, e_next;
    operand_t result_reg, result_next;
    cnt_t     cnt_reg, cnt_next;
    logic     phase_sq_reg, phase_sq_next;

    operand_t unit_b;
    logic     unit_cin;
    operand_t unit_y;
    logic     end_bit;

    mexp_addmod u_addmod (
        .a_in   (r_reg),
        .b_in   (unit_b),
        .cin    (unit_cin),
        .mod_in (cfg.modulus),
        .y_out  (unit_y)
    );

    always_comb begin
        state_next    = state_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        sq_next       = sq_reg;
        r_next        = r_reg;
        e_next        = e_reg;
        result_next   = result_reg;
        cnt_next      = cnt_reg;
        phase_sq_next = phase_sq_reg;
        end_bit       = 1'b0;
        unit_b        = r_reg;
        unit_cin      = 1'b0;

        unique case (state_reg)
            ST_REDUCE: begin
                unit_cin = base_reg[cnt_reg];
            end
            ST_ADD: begin
                unit_b = phase_sq_reg ? sq_reg : acc_reg;
            end
            default: begin
                unit_b = r_reg;
            end
        endcase

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (cfg.exponent == '0) begin
                        result_next = OP_BITS'(1);
                        state_next  = ST_DONE;
                    end else if (cfg.modulus == '0) begin
                        result_next = '0;
                        state_next  = ST_DONE;
                    end else begin
                        base_next  = base_value;
                        acc_next   = (cfg.modulus == OP_BITS'(1)) ? '0 : OP_BITS'(1);
                        e_next     = cfg.exponent;
                        r_next     = '0;
                        cnt_next   = CNT_MAX;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                // Shift the base in one bit a cycle, reducing as it goes
                r_next = unit_y;
                if (cnt_reg == '0) begin
                    sq_next    = unit_y;
                    state_next = ST_NEXT;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_NEXT: begin
                phase_sq_next = ~e_reg[0];
                r_next        = '0;
                cnt_next      = CNT_MAX;
                state_next    = ST_DBL;
            end
            ST_DBL: begin
                r_next = unit_y;
                if (sq_reg[cnt_reg]) begin
                    state_next = ST_ADD;
                end else begin
                    end_bit = 1'b1;
                end
            end
            ST_ADD: begin
                r_next  = unit_y;
                end_bit = 1'b1;
            end
            ST_DONE: begin
                if (done_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (end_bit) begin
            if (cnt_reg != '0) begin
                cnt_next   = cnt_reg - 1'b1;
                state_next = ST_DBL;
            end else if (!phase_sq_reg) begin
                acc_next = unit_y;
                if (e_reg[OP_BITS-1:1] == '0) begin
                    // No exponent bits left: the square is never needed
                    result_next = unit_y;
                    state_next  = ST_DONE;
                end else begin
                    phase_sq_next = 1'b1;
                    r_next        = '0;
                    cnt_next      = CNT_MAX;
                    state_next    = ST_DBL;
                end
            end else begin
                sq_next    = unit_y;
                e_next     = e_reg >> 1;
                state_next = ST_NEXT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        r_reg        <= r_next;
        e_reg        <= e_next;
        result_reg   <= result_next;
        cnt_reg      <= cnt_next;
        phase_sq_reg <= phase_sq_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done_valid = (state_reg == ST_DONE);
    assign result     = result_reg;

endmodule

// ----- rtl/modular_exponentiation_top.sv -----
// Top level of the modular exponentiation block: APB registers and result slot.
// Depends on mexp_pkg and mexp_core.
//
// Usage: write the exponent (address 0) and modulus (address 4) over the APB
// port while the block is idle; both apply to every following request. Each
// request on the s_ channel carries one base value; exactly one result leaves
// on the m_ channel for each, in order.
// Operation: a request is held while the core works on it, so s_ready is low
// until the core is free. The core runs one add-compare-subtract step per
// cycle in its reduce, double and add states: it first reduces the base one
// bit at a time, then for each exponent bit passes a setup state, does a
// multiply when the bit is set and a squaring for every bit below the top
// one. A multiply doubles once for each bit of the square and adds once for
// each set bit. An exponent of zero or a zero modulus skip these steps and
// go straight to the done state.
// Stall: a finished result waits in the output register until m_ready; the
// core accepts the next request meanwhile and holds its own result in its
// done state until the output register frees up.
// Reset: aresetn (synchronous, active low) drops any request in flight,
// empties the output register and sets exponent 0 and modulus 1.
module modular_exponentiation_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mexp_pkg::operand_t   s_base_value,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output mexp_pkg::operand_t   m_power_result
);
    import mexp_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     m_valid_reg, m_valid_next;
    operand_t m_power_result_reg, m_power_result_next;

    logic     cfg_write;
    logic     core_busy;
    logic     core_done;
    logic     core_take;
    operand_t core_result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Register index is the word address
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                REG_EXPONENT: cfg_next.exponent = pwdata[OP_BITS-1:0];
                REG_MODULUS:  cfg_next.modulus  = pwdata[OP_BITS-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_EXPONENT: prdata = 32'(cfg_reg.exponent);
            REG_MODULUS:  prdata = 32'(cfg_reg.modulus);
            default:      prdata = '0;
        endcase
    end

    mexp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .start      (s_valid && s_ready),
        .base_value (s_base_value),
        .busy       (core_busy),
        .done_valid (core_done),
        .done_take  (core_take),
        .result     (core_result)
    );

    // Take a request only when the core is free
    assign s_ready = !core_busy;

    // Move the core's result into the output slot whenever it is empty or draining
    assign core_take = core_done && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next        = m_valid_reg;
        m_power_result_next = m_power_result_reg;
        if (core_take) begin
            m_valid_next        = 1'b1;
            m_power_result_next = core_result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.exponent <= '0;
            cfg_reg.modulus  <= OP_BITS'(1);
            m_valid_reg      <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_power_result_reg <= m_power_result_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_power_result = m_power_result_reg;

endmodule

// ----- sim/modular_exponentiation_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for modular_exponentiation_top: programs exponent and modulus over APB,
// streams base-value requests with random idling on both channels and checks every result against
// a known value or an in-bench square-and-multiply predictor. Depends on mexp_pkg and the RTL.
module modular_exponentiation_top_tb;
    import mexp_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQUESTS = 29;
    localparam int DIRECTED_ROWS  = 23;
    // Longest sender gap, longest receiver stall and the core's worst case per request
    localparam int MAX_GAP        = 400;
    localparam int MAX_STALL      = 800;
    localparam int CORE_WORST     = 4000;
    localparam int DRAIN_CYCLES   = 100;
    // Every request at its slowest, taken four times over
    localparam int unsigned CYCLE_LIMIT =
        4 * (DIRECTED_ROWS + RANDOM_PHASES * PHASE_REQUESTS) * (CORE_WORST + MAX_GAP + MAX_STALL)
        + 10000;

    localparam logic     APB_READ  = 1'b0;
    localparam logic     APB_WRITE = 1'b1;
    localparam operand_t OP_ONES   = '1;
    localparam operand_t OP_TOP    = operand_t'(1) << (OP_BITS - 1);

    typedef enum logic [1:0] {
        RX_FLOW,    // accept every cycle
        RX_COIN,    // accept on a coin toss
        RX_BLOCK    // hold results back for a whole stretch
    } rx_mode_t;

    // One directed row: the register setting it needs, the base, and the result
    // where it is plain to see (known = 1); other rows go through the predictor.
    typedef struct packed {
        operand_t exponent;
        operand_t modulus;
        operand_t base;
        logic     known;
        operand_t power;
    } vector_t;

    vector_t directed_rows [DIRECTED_ROWS] = '{
        // reset setting: exponent zero gives 1
        '{31'd0,       31'd1,          31'd0,          1'b1, 31'd1},
        '{31'd0,       31'd1,          OP_ONES,        1'b1, 31'd1},
        // modulus one with a nonzero exponent gives 0
        '{31'd1,       31'd1,          31'd5,          1'b1, 31'd0},
        '{OP_ONES,     31'd1,          OP_ONES,        1'b1, 31'd0},
        // modulus zero: exponent zero still gives 1, otherwise 0
        '{31'd0,       31'd0,          31'd123,        1'b1, 31'd1},
        '{31'd5,       31'd0,          31'd9,          1'b1, 31'd0},
        '{OP_ONES,     31'd0,          OP_ONES,        1'b1, 31'd0},
        // largest modulus; base equal to, just below and far below it
        '{31'd1,       OP_ONES,        OP_ONES,        1'b1, 31'd0},
        '{31'd1,       OP_ONES,        31'h7FFF_FFFE,  1'b1, 31'h7FFF_FFFE},
        '{31'd1,       OP_ONES,        31'd0,          1'b1, 31'd0},
        '{31'd2,       OP_ONES,        31'h7FFF_FFFE,  1'b1, 31'd1},
        '{OP_ONES,     OP_ONES,        31'h7FFF_FFFE,  1'b1, 31'h7FFF_FFFE},
        '{OP_ONES,     OP_ONES,        31'h1234_5678,  1'b0, 31'd0},
        // base above the modulus is reduced first; then 2^30 and 2^31 mod 2^31 - 1
        '{OP_ONES,     31'h7FFF_FFFE,  OP_ONES,        1'b1, 31'd1},
        '{31'd30,      OP_ONES,        31'd2,          1'b1, 31'h4000_0000},
        '{31'd31,      OP_ONES,        31'd2,          1'b1, 31'd1},
        // small textbook key pair: encrypt then decrypt; then mixed edge cases
        '{31'd17,      31'd3233,       31'd65,         1'b1, 31'd2790},
        '{31'd2753,    31'd3233,       31'd2790,       1'b1, 31'd65},
        '{31'h5555_5555, 31'h2AAA_AAAB, OP_ONES,       1'b0, 31'd0},
        '{31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA, 1'b0, 31'd0},
        '{31'd1,       31'd2,          OP_ONES,        1'b1, 31'd1},
        '{31'd0,       31'd2,          31'd55,         1'b1, 31'd1},
        '{31'd65537,   OP_ONES,        31'd1,          1'b1, 31'd1}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    operand_t    s_base_value;
    logic        m_valid;
    logic        m_ready;
    operand_t    m_power_result;

    // Shadow of the register setting the predictor works with
    operand_t    cfg_exponent;
    operand_t    cfg_modulus;
    // Results owed by the block, oldest first
    operand_t    pending_powers [$];
    int unsigned error_count  = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;
    int unsigned burst_left   = 0;

    modular_exponentiation_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_base_value   (s_base_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_power_result (m_power_result)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Right-to-left square-and-multiply on 64-bit products; two residues below
    // 2^31 never overflow.
    function automatic operand_t expected_power(input operand_t base, input operand_t power_exp,
                                                input operand_t modv);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned m;
        operand_t        bits_left;
        if (power_exp == '0) begin
            return operand_t'(1);
        end
        if (modv == '0) begin
            return '0;
        end
        m         = modv;
        acc       = 1 % m;
        sq        = base % m;
        bits_left = power_exp;
        while (bits_left != '0) begin
            if (bits_left[0]) begin
                acc = (acc * sq) % m;
            end
            sq        = (sq * sq) % m;
            bits_left = bits_left >> 1;
        end
        return operand_t'(acc);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // One APB transfer: setup cycle, access cycle until pready, then back to idle
    task automatic apb_transfer(input logic write_en, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input logic reg_idx, input operand_t want);
        logic [31:0] rd;
        apb_transfer(APB_READ, {reg_idx, 2'b00}, 32'h0, rd);
        if (rd[OP_BITS-1:0] !== want) begin
            report_mismatch($sformatf("register %0d reads 0x%08h, expected 0x%08h",
                                      reg_idx, rd, want));
        end
    endtask

    // Write a register with a random spare top bit, which the block must drop, then read it back
    task automatic set_reg(input logic reg_idx, input operand_t value);
        logic [31:0] rd;
        apb_transfer(APB_WRITE, {reg_idx, 2'b00},
                     32'(value) | (32'($urandom_range(0, 1)) << 31), rd);
        check_reg(reg_idx, value);
    endtask

    // Drain every owed result before touching the registers
    task automatic apply_config(input operand_t new_exp, input operand_t new_mod);
        s_valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        set_reg(REG_EXPONENT, new_exp);
        set_reg(REG_MODULUS, new_mod);
        cfg_exponent = new_exp;
        cfg_modulus  = new_mod;
    endtask

    // Present one request, hold it until accepted, then either keep the burst
    // going or drop valid for a random gap with junk on the payload.
    task automatic issue_base(input operand_t base, input operand_t power);
        s_valid      <= 1'b1;
        s_base_value <= base;
        do @(posedge aclk); while (!s_ready);
        pending_powers.push_back(power);
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            s_valid      <= 1'b0;
            s_base_value <= operand_t'($urandom);
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(50, MAX_GAP)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 5);
        end
    endtask

    // Receiver: stretches of free flow, coin-toss acceptance and hard blocking
    initial begin : result_sink
        rx_mode_t    mode;
        int unsigned stretch_left;
        m_ready      = 1'b0;
        mode         = RX_FLOW;
        stretch_left = 0;
        forever begin
            @(posedge aclk);
            if (stretch_left == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        mode         = RX_FLOW;
                        stretch_left = $urandom_range(20, 400);
                    end
                    4, 5, 6, 7: begin
                        mode         = RX_COIN;
                        stretch_left = $urandom_range(20, 400);
                    end
                    default: begin
                        mode         = RX_BLOCK;
                        stretch_left = $urandom_range(1, MAX_STALL);
                    end
                endcase
            end
            stretch_left--;
            case (mode)
                RX_FLOW: m_ready <= 1'b1;
                RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= 1'b0;
            endcase
        end
    end

    // Compare every accepted result with the oldest owed one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_powers.size() == 0) begin
                report_mismatch($sformatf("result %0d: 0x%08h with no request outstanding",
                                          results_seen, m_power_result));
            end else begin
                if (m_power_result !== pending_powers[0]) begin
                    report_mismatch($sformatf("result %0d: power_result 0x%08h, expected 0x%08h",
                                              results_seen, m_power_result, pending_powers[0]));
                end
                void'(pending_powers.pop_front());
            end
        end
    end

    // Timeout
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        operand_t base;
        operand_t new_exp;
        operand_t new_mod;
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_base_value = '0;
        cfg_exponent = '0;
        cfg_modulus  = operand_t'(1);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values first: exponent 0, modulus 1
        check_reg(REG_EXPONENT, '0);
        check_reg(REG_MODULUS, operand_t'(1));

        // Directed table; reprogram only when a row needs another setting
        foreach (directed_rows[i]) begin
            if (directed_rows[i].exponent != cfg_exponent ||
                directed_rows[i].modulus != cfg_modulus) begin
                apply_config(directed_rows[i].exponent, directed_rows[i].modulus);
            end
            issue_base(directed_rows[i].base,
                       directed_rows[i].known ? directed_rows[i].power
                                              : expected_power(directed_rows[i].base,
                                                               cfg_exponent, cfg_modulus));
        end

        // Random phases: exponent length cycles through short, medium, full and
        // the usual public exponents; most requests stay cheap, a few run all 31 bits.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0:       new_exp = operand_t'($urandom_range(1, 255));
                1:       new_exp = operand_t'($urandom_range(256, 1048575));
                2:       new_exp = operand_t'($urandom) | OP_TOP;
                default: new_exp = ($urandom_range(0, 1) != 0) ? operand_t'(65537)
                                                                : operand_t'(17);
            endcase
            if ($urandom_range(0, 11) == 0) begin
                new_exp = '0;
            end
            case ($urandom_range(0, 6))
                0:       new_mod = OP_ONES;
                1:       new_mod = operand_t'($urandom) | OP_TOP;
                2:       new_mod = operand_t'($urandom_range(2, 255));
                3:       new_mod = operand_t'($urandom_range(256, 65535));
                4:       new_mod = operand_t'(1);
                default: new_mod = operand_t'($urandom_range(1, OP_ONES));
            endcase
            if ($urandom_range(0, 15) == 0) begin
                new_mod = '0;
            end
            apply_config(new_exp, new_mod);

            repeat (PHASE_REQUESTS) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: base = operand_t'($urandom);
                    4, 5:       base = operand_t'($urandom_range(0, 255));
                    6:          base = cfg_modulus - operand_t'(1);
                    7:          base = cfg_modulus + operand_t'($urandom_range(0, 3));
                    8: begin
                        case ($urandom_range(0, 2))
                            0:       base = '0;
                            1:       base = operand_t'(1);
                            default: base = OP_ONES;
                        endcase
                    end
                    default:    base = operand_t'($urandom) >> $urandom_range(0, OP_BITS - 1);
                endcase
                issue_base(base, expected_power(base, cfg_exponent, cfg_modulus));
            end
        end

        // Release the channel, wait for every owed result, then let stragglers show up
        s_valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
